// File: src/nearest_point_table_search_core_defines.svh
// ----------------------------------------------------------------------------
// Nearest point table search: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_TABLE_SEARCH_CORE_DEFINES_SVH
`define NEAREST_POINT_TABLE_SEARCH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Like NPTS_ASSERT_NEXT, with a further delay before the consequent must hold.
`define NPTS_ASSERT_LATER(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

// File: src/npts_pkg.sv
// ----------------------------------------------------------------------------
// Nearest point table search: package
// Widths, request and status codes, and the types shared between modules.
// ----------------------------------------------------------------------------
package npts_pkg;

    localparam int MAX_POINTS_DEF = 32;

    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int DATA_W       = 32;
    localparam int COARSE_SHIFT = 20;
    localparam int COARSE_W     = DATA_W - COARSE_SHIFT;
    localparam int SQ_W         = 2 * COARSE_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int HIT_INDEX_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Search token handed from cell to cell: the coarse query and the best
    // point seen so far.
    typedef struct packed {
        logic [COARSE_W-1:0]    qx;
        logic [COARSE_W-1:0]    qy;
        logic                   found;
        logic [HIT_INDEX_W-1:0] idx;
        logic [DIST_W-1:0]      best_dist;
        logic [DATA_W-1:0]      x;
        logic [DATA_W-1:0]      y;
        logic [DATA_W-1:0]      h;
    } token_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HIT_INDEX_W-1:0] hit_index;
        logic [DATA_W-1:0]      hit_x;
        logic [DATA_W-1:0]      hit_y;
        logic [DATA_W-1:0]      hit_height;
        logic [DIST_W-1:0]      distance;
    } result_t;

endpackage

// File: src/npts_if.sv
// ----------------------------------------------------------------------------
// Nearest point table search: channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface npts_req_if;
    logic                         valid;
    logic                         ready;
    logic [npts_pkg::FUNC_W-1:0]  func;
    logic [npts_pkg::DATA_W-1:0]  pos_x;
    logic [npts_pkg::DATA_W-1:0]  pos_y;
    logic [npts_pkg::DATA_W-1:0]  height;

    modport source (output valid, func, pos_x, pos_y, height, input ready);
    modport sink   (input valid, func, pos_x, pos_y, height, output ready);
endinterface

interface npts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [npts_pkg::STATUS_W-1:0]     status;
    logic [npts_pkg::HIT_INDEX_W-1:0]  hit_index;
    logic [npts_pkg::DATA_W-1:0]       hit_x;
    logic [npts_pkg::DATA_W-1:0]       hit_y;
    logic [npts_pkg::DATA_W-1:0]       hit_height;
    logic [npts_pkg::DIST_W-1:0]       distance;

    modport source (output valid, status, hit_index, hit_x, hit_y, hit_height, distance,
                    input ready);
    modport sink   (input valid, status, hit_index, hit_x, hit_y, hit_height, distance,
                    output ready);
endinterface

// File: src/npts_cell.sv
// ----------------------------------------------------------------------------
// Nearest point table search: table cell
// Holds one point and updates the passing search token with it.
// ----------------------------------------------------------------------------
module npts_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CNT_W-1:0]            count,
    input  logic                        wr_en,
    input  logic [npts_pkg::DATA_W-1:0] wr_x,
    input  logic [npts_pkg::DATA_W-1:0] wr_y,
    input  logic [npts_pkg::DATA_W-1:0] wr_h,
    input  logic                        tok_valid_in,
    input  npts_pkg::token_t            tok_in,
    output logic                        tok_valid_out,
    output npts_pkg::token_t            tok_out
);

    localparam logic [CNT_W-1:0] CELL_ID = CNT_W'(CELL_IDX);
    localparam logic [npts_pkg::HIT_INDEX_W-1:0] CELL_HIT = npts_pkg::HIT_INDEX_W'(CELL_IDX);

    logic [npts_pkg::DATA_W-1:0]   x_reg, x_next;
    logic [npts_pkg::DATA_W-1:0]   y_reg, y_next;
    logic [npts_pkg::DATA_W-1:0]   h_reg, h_next;
    logic                          tok_valid_reg, tok_valid_next;
    npts_pkg::token_t              tok_reg, tok_next;

    logic [npts_pkg::COARSE_W-1:0] px;
    logic [npts_pkg::COARSE_W-1:0] py;
    logic [npts_pkg::COARSE_W-1:0] dx;
    logic [npts_pkg::COARSE_W-1:0] dy;
    logic [npts_pkg::SQ_W-1:0]     dx_sq;
    logic [npts_pkg::SQ_W-1:0]     dy_sq;
    logic [npts_pkg::DIST_W-1:0]   cand_dist;
    logic                          in_use;
    logic                          take;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        h_next = h_reg;
        if (wr_en && (count == CELL_ID))
        begin
            x_next = wr_x;
            y_next = wr_y;
            h_next = wr_h;
        end
    end

    always_comb
    begin
        px        = x_reg[npts_pkg::DATA_W-1 -: npts_pkg::COARSE_W];
        py        = y_reg[npts_pkg::DATA_W-1 -: npts_pkg::COARSE_W];
        dx        = (px >= tok_in.qx) ? (px - tok_in.qx) : (tok_in.qx - px);
        dy        = (py >= tok_in.qy) ? (py - tok_in.qy) : (tok_in.qy - py);
        dx_sq     = dx * dx;
        dy_sq     = dy * dy;
        cand_dist = {1'b0, dx_sq} + {1'b0, dy_sq};
        in_use    = (CELL_ID < count);
        // Strict compare keeps the lower index on equal distances.
        take      = in_use && (!tok_in.found || (cand_dist < tok_in.best_dist));

        tok_valid_next = tok_valid_in;
        tok_next       = tok_in;
        if (take)
        begin
            tok_next.found     = 1'b1;
            tok_next.idx       = CELL_HIT;
            tok_next.best_dist = cand_dist;
            tok_next.x         = x_reg;
            tok_next.y         = y_reg;
            tok_next.h         = h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        h_reg   <= h_next;
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: src/nearest_point_table_search_core.sv
// Add, clear and a find on an empty table are answered from the pending slot, then the output register.
// A find answers once the search token has left the last cell: the token crosses one
// cell per cycle, so the length of the cell row sets how long a search runs.
// A new request is taken only once any search has ended and the pending slot is free.
// Reset: the table is emptied and all valid flags clear; stored points are not cleared.
// ----------------------------------------------------------------------------
// Nearest point table search core
// A row of cells, one per table entry, each holding a point. Adds write the
// cell at the current fill count. A find sends a token down the row; each
// cell in use compares its coarse squared distance to the query against the
// best so far and replaces it when strictly smaller, so the lowest index wins
// a tie. Results pass through a pending slot and an output register, so one
// new request is taken while a finished response still waits downstream.
// ----------------------------------------------------------------------------
module nearest_point_table_search_core #(
    parameter int MAX_POINTS = npts_pkg::MAX_POINTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    npts_req_if.sink   req,
    npts_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Fill count of the table; cells at or above it are not in use.
    logic [CNT_W-1:0]    count_reg, count_next;
    // A search token is travelling down the row.
    logic                scan_reg, scan_next;
    // Pending result slot in front of the output register.
    logic                pend_valid_reg, pend_valid_next;
    npts_pkg::result_t   pend_reg, pend_next;
    // Output register driving the response channel.
    logic                out_valid_reg, out_valid_next;
    npts_pkg::result_t   out_reg, out_next;

    logic                tok_valid [0:MAX_POINTS];
    npts_pkg::token_t    tok       [0:MAX_POINTS];

    logic                busy;
    logic                accept;
    logic                table_full;
    logic                table_empty;
    logic                inject;
    logic                wr_en;
    logic                move;
    npts_pkg::result_t   imm_res;
    npts_pkg::result_t   scan_res;

    // The block takes a request only when no search is running and the
    // pending slot is free; the output register may still hold a response.
    assign busy        = scan_reg || pend_valid_reg;
    assign req.ready   = !busy;
    assign accept      = req.valid && !busy;
    assign table_full  = (count_reg == CNT_W'(MAX_POINTS));
    assign table_empty = (count_reg == '0);
    assign inject      = accept && (req.func == npts_pkg::FUNC_FIND) && !table_empty;
    assign wr_en       = accept && (req.func == npts_pkg::FUNC_ADD) && !table_full;
    assign move        = pend_valid_reg && (!out_valid_reg || rsp.ready);

    // The token starts with the coarse query and no best point yet.
    always_comb
    begin
        tok_valid[0]    = inject;
        tok[0]          = '0;
        tok[0].qx       = req.pos_x[npts_pkg::DATA_W-1 -: npts_pkg::COARSE_W];
        tok[0].qy       = req.pos_y[npts_pkg::DATA_W-1 -: npts_pkg::COARSE_W];
    end

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        npts_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .count         (count_reg),
            .wr_en         (wr_en),
            .wr_x          (req.pos_x),
            .wr_y          (req.pos_y),
            .wr_h          (req.height),
            .tok_valid_in  (tok_valid[i]),
            .tok_in        (tok[i]),
            .tok_valid_out (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    // Responses that need no search: every field but status is zero.
    always_comb
    begin
        imm_res = '0;
        unique case (req.func)
            npts_pkg::FUNC_ADD:
            begin
                imm_res.status = table_full ? npts_pkg::STATUS_FULL : npts_pkg::STATUS_OK;
            end
            npts_pkg::FUNC_FIND:
            begin
                imm_res.status = table_empty ? npts_pkg::STATUS_EMPTY : npts_pkg::STATUS_OK;
            end
            default:
            begin
                imm_res.status = npts_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        scan_res            = '0;
        scan_res.status     = npts_pkg::STATUS_OK;
        scan_res.hit_index  = tok[MAX_POINTS].idx;
        scan_res.hit_x      = tok[MAX_POINTS].x;
        scan_res.hit_y      = tok[MAX_POINTS].y;
        scan_res.hit_height = tok[MAX_POINTS].h;
        scan_res.distance   = tok[MAX_POINTS].best_dist;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            unique case (req.func)
                npts_pkg::FUNC_ADD:
                begin
                    if (!table_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                npts_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (inject)
        begin
            scan_next = 1'b1;
        end
        else if (tok_valid[MAX_POINTS])
        begin
            scan_next = 1'b0;
        end
    end

    // The pending slot is always empty when a search ends or a request is
    // taken, since either one keeps the block busy until the slot drains.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (move)
        begin
            pend_valid_next = 1'b0;
        end
        if (tok_valid[MAX_POINTS])
        begin
            pend_valid_next = 1'b1;
            pend_next       = scan_res;
        end
        else if (accept && !inject)
        begin
            pend_valid_next = 1'b1;
            pend_next       = imm_res;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.hit_index  = out_reg.hit_index;
    assign rsp.hit_x      = out_reg.hit_x;
    assign rsp.hit_y      = out_reg.hit_y;
    assign rsp.hit_height = out_reg.hit_height;
    assign rsp.distance   = out_reg.distance;

endmodule

// File: src/npts_checker.sv
// ----------------------------------------------------------------------------
// Nearest point table search: port checker
// Watches the request and response channels of the core over time.
// ----------------------------------------------------------------------------
`include "nearest_point_table_search_core_defines.svh"

module npts_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic [npts_pkg::FUNC_W-1:0]      req_func,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [npts_pkg::STATUS_W-1:0]    rsp_status,
    input logic [npts_pkg::HIT_INDEX_W-1:0] rsp_hit_index,
    input logic [npts_pkg::DATA_W-1:0]      rsp_hit_x,
    input logic [npts_pkg::DATA_W-1:0]      rsp_hit_y,
    input logic [npts_pkg::DATA_W-1:0]      rsp_hit_height,
    input logic [npts_pkg::DIST_W-1:0]      rsp_distance
);

    logic req_take;
    logic rsp_refused;
    logic rsp_zero;

    assign req_take    = req_valid && req_ready;
    assign rsp_refused = rsp_valid && ((rsp_status == npts_pkg::STATUS_FULL) ||
                                       (rsp_status == npts_pkg::STATUS_EMPTY));
    assign rsp_zero    = (rsp_hit_index == '0) && (rsp_hit_x == '0) && (rsp_hit_y == '0) &&
                         (rsp_hit_height == '0) && (rsp_distance == '0);

    // A response waiting downstream stays offered.
    `NPTS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // One request at a time: the core is busy right after taking one.
    `NPTS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_take, !req_ready, "second request taken back to back")

    // A full or empty status carries no point.
    `NPTS_ASSERT_SAME(a_refusal_zero, clk, rst_n, rsp_refused, rsp_zero, "refusal with nonzero fields")

    // Non-find requests are answered via the pending slot and output register.
    `NPTS_ASSERT_LATER(a_quick_reply, clk, rst_n, req_take && (req_func != npts_pkg::FUNC_FIND), rsp_valid, "quick response missing")

endmodule

bind nearest_point_table_search_core npts_checker u_npts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_func       (req.func),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_hit_index  (rsp.hit_index),
    .rsp_hit_x      (rsp.hit_x),
    .rsp_hit_y      (rsp.hit_y),
    .rsp_hit_height (rsp.hit_height),
    .rsp_distance   (rsp.distance)
);
